@@ design/sfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Constants and codes for the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0] START_MARK = 8'hA5;
  localparam logic [7:0] END_MARK   = 8'hFA;

  localparam int BODY_LEN  = 22;   // long frame body length
  localparam int ID_FIRST  = 3;    // first identifier index in the body
  localparam int ID_COUNT  = 18;   // identifier bytes per long frame
  localparam int BODY_AW   = 5;    // body address width
  localparam int POS_W     = 5;    // identifier position width
  localparam int OUT_DATA_W = 56;  // 53 payload bits padded to bytes

  localparam logic [BODY_AW-1:0] BODY_LAST    = BODY_AW'(BODY_LEN - 1);
  localparam logic [POS_W-1:0]   ID_POS_LAST  = POS_W'(ID_COUNT - 1);
  localparam logic [BODY_AW-1:0] ID_FIRST_ADR = BODY_AW'(ID_FIRST);
  localparam logic [BODY_AW-1:0] HEAD0_ADR    = BODY_AW'(0);
  localparam logic [BODY_AW-1:0] HEAD2_ADR    = BODY_AW'(2);

  typedef enum logic [1:0] {
    KIND_COMMAND = 2'd0,
    KIND_STATUS  = 2'd1,
    KIND_ID      = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [2:0]       pad;
    logic [7:0]       header_third;
    logic [7:0]       header_first;
    logic [POS_W-1:0] id_position;
    logic [7:0]       id_byte;
    logic [7:0]       module_status;
    logic [7:0]       command_value;
    logic [7:0]       command_type;
  } out_data_t;

endpackage
`default_nettype wire

@@ design/serial_frame_receiver_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver_top
// Watches a stream of received UART bytes for short command/status frames
// and collects long frames whose identifier bytes are read out one by one.
//
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid/s_tready      s_tdata: rx_byte
// m_*       out  m_tvalid/m_tready      m_tdata/m_tuser/m_tlast: one result
//
// A byte that causes no long frame readout is simply accepted; its result,
// if any, sits in the output register. A byte that completes a good long
// frame is accepted, then makes 18 reads of the body memory,
// one identifier a cycle. The single body memory read port sets that pace.
// rst is synchronous; it clears the window, collection state and output.
// A stall on m_tready holds the readout and blocks new input bytes.
// ----------------------------------------------------------------------------
module serial_frame_receiver_top
  import sfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [7:0] command_type, [15:8] command_value, [23:16] module_status,
  // [31:24] id_byte, [36:32] id_position, [44:37] header_first,
  // [52:45] header_third, [55:53] zero
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic [1:0]                 m_tuser,   // [1:0] event_kind
  output logic                       m_tlast
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t              state;
  logic [7:0]          win [4];     // win[0] oldest
  logic                collecting;
  logic [BODY_AW-1:0]  body_count;
  logic [7:0]          head0;
  logic [7:0]          head2;
  logic [POS_W-1:0]    q_pos;       // position of the byte in mem_q

  logic [7:0]          body_mem [BODY_LEN];
  logic [7:0]          mem_q;
  logic                rd_en;
  logic [BODY_AW-1:0]  rd_addr;
  logic                wr_en;

  logic                accept;
  logic                out_free;
  logic                cmd_hit;
  logic                stat_hit;
  logic                coll_eff;
  logic                start_hit;
  logic                id_go;
  logic [8:0]          sum9;
  out_data_t           res;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign sum9      = {1'b0, win[1]} + {1'b0, win[2]};
  assign cmd_hit   = (win[0] == START_MARK) && (s_tdata == END_MARK) &&
                     ({1'b0, win[3]} == sum9);
  // an A5..FA window suppresses the status test, whatever its checksum
  assign stat_hit  = !((win[0] == START_MARK) && (s_tdata == END_MARK)) &&
                     (win[2] == START_MARK) && (s_tdata == END_MARK);
  assign coll_eff  = collecting && !cmd_hit && !stat_hit;
  assign start_hit = (s_tdata == START_MARK) && !coll_eff;
  assign wr_en     = accept && coll_eff;
  assign id_go     = wr_en && (body_count == BODY_LAST) && (s_tdata == END_MARK);

  // writes only on accept; reads in readout and on the write of the last body byte
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ID_FIRST_ADR;
    if (id_go) begin
      rd_en = 1'b1;
    end else if (state == ST_READ && out_free && q_pos != ID_POS_LAST) begin
      rd_en   = 1'b1;
      rd_addr = BODY_AW'(q_pos) + ID_FIRST_ADR + BODY_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      body_mem[body_count] <= s_tdata;
    end
    if (rd_en) begin
      mem_q <= body_mem[rd_addr];
    end
  end

  always_comb begin
    res               = '0;
    res.id_byte       = mem_q;
    res.id_position   = q_pos;
    res.header_first  = head0;
    res.header_third  = head2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      win        <= '{default: 8'h00};
      collecting <= 1'b0;
      body_count <= '0;
      q_pos      <= '0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
      m_tuser    <= '0;
      m_tlast    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (cmd_hit || stat_hit)) begin
            m_tvalid <= 1'b1;
            m_tlast  <= 1'b1;
            if (cmd_hit) begin
              m_tuser <= KIND_COMMAND;
              m_tdata <= OUT_DATA_W'({win[2], win[1]});
            end else begin
              m_tuser <= KIND_STATUS;
              m_tdata <= OUT_DATA_W'({win[3], 16'h0000});
            end
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end

          if (accept) begin
            win[0] <= win[1];
            win[1] <= win[2];
            win[2] <= win[3];
            win[3] <= s_tdata;

            if (start_hit) begin
              collecting <= 1'b1;
              body_count <= '0;
            end else if (coll_eff) begin
              if (body_count == HEAD0_ADR) begin
                head0 <= s_tdata;
              end
              if (body_count == HEAD2_ADR) begin
                head2 <= s_tdata;
              end
              if (body_count == BODY_LAST) begin
                collecting <= 1'b0;
                body_count <= '0;
                if (id_go) begin
                  state <= ST_READ;
                  q_pos <= '0;
                end
              end else begin
                body_count <= body_count + BODY_AW'(1);
              end
            end else begin
              collecting <= 1'b0;
              body_count <= '0;
            end
          end
        end
        ST_READ: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= KIND_ID;
            m_tdata  <= res;
            m_tlast  <= (q_pos == ID_POS_LAST);
            if (q_pos == ID_POS_LAST) begin
              state <= ST_IDLE;
            end else begin
              q_pos <= q_pos + POS_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
      endcase
    end
  end

  // readout and input acceptance are exclusive
  a_no_accept_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !s_tready)
    else $error("input accepted during identifier readout");

  // the last identifier of a frame is at the final position
  a_id_last_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && m_tuser == KIND_ID) |-> (m_tdata[36:32] == ID_POS_LAST))
    else $error("identifier readout ended at the wrong position");

  // body count stays inside the body memory
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    collecting |-> (body_count <= BODY_LAST))
    else $error("body count out of range");

  // a completed good long frame always starts a readout
  a_id_go_read: assert property (@(posedge clk) disable iff (rst)
    id_go |=> (state == ST_READ && q_pos == '0))
    else $error("long frame readout did not start");

endmodule
`default_nettype wire
